// ----- rtl/core/rxrs_pkg.sv -----
// package for the range xor / range sum store
// holds shared widths, request codes and state encoding; no dependencies
package rxrs_pkg;

    localparam int POS_W = 11;
    localparam int SUM_W = 30;
    localparam int TYPE_W = 2;
    localparam logic [POS_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_XOR   = 2'd1,
        REQ_SUM   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/rxrs_elem_ram.sv -----
// element memory: one write port, one registered read port
// depends on nothing; sized by the top level
module rxrs_elem_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/range_xor_range_sum_tree.sv -----
// Range xor / range sum store. Holds MAX_ELEMENTS values of VALUE_BITS bits at
// positions 1..MAX_ELEMENTS in one element memory, swept by one shared
// read-modify-write unit. A load writes its element directly from idle. A range
// xor or range sum reads one element per position from the registered read
// port, and a sum then holds its item in the output register until taken.
// After reset a clearing pass zeroes the memory; no item is accepted until it
// ends. Depends on rxrs_pkg, rxrs_elem_ram.
module range_xor_range_sum_tree #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rxrs_pkg::POS_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rxrs_pkg::TYPE_W-1:0] s_req_type,
    input  logic [rxrs_pkg::POS_W-1:0]  s_left,
    input  logic [rxrs_pkg::POS_W-1:0]  s_right,
    input  logic [VALUE_BITS-1:0]       s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rxrs_pkg::SUM_W-1:0]  m_range_sum
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PW = rxrs_pkg::POS_W;
    localparam int SW = rxrs_pkg::SUM_W;

    rxrs_pkg::state_t state_reg, state_next;
    logic [PW-1:0]         count_reg;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [PW-1:0]         cur_reg, cur_next;
    logic [PW-1:0]         end_reg, end_next;
    logic                  is_sum_reg, is_sum_next;
    logic [VALUE_BITS-1:0] mask_reg, mask_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         paddr_reg, paddr_next;
    logic [SW-1:0]         acc_reg, acc_next;

    logic [31:0]           cnt32;
    logic [PW-1:0]         cnt;
    logic [PW-1:0]         l_eff, r_eff;
    logic                  accept;
    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;
    logic [31:0]           rd32;

    // effective count and clipped range
    always_comb begin
        cnt32 = (32'(count_reg) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : 32'(count_reg);
        cnt   = cnt32[PW-1:0];
        l_eff = (s_left == '0) ? PW'(1) : s_left;
        r_eff = (s_right > cnt) ? cnt : s_right;
    end

    // position to memory address
    function automatic logic [AW-1:0] pos_addr(input logic [PW-1:0] pos);
        logic [31:0] t;
        t = 32'(pos) - 32'd1;
        return t[AW-1:0];
    endfunction

    assign accept      = s_valid && s_ready;
    assign rd32        = 32'(rdata);
    assign m_range_sum = acc_reg;

    // sequencer and shared read-modify-write unit
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        end_next    = end_reg;
        is_sum_next = is_sum_reg;
        mask_next   = mask_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        acc_next    = acc_reg;
        we          = 1'b0;
        waddr       = paddr_reg;
        wdata       = rdata ^ mask_reg;
        raddr       = pos_addr(cur_reg);
        s_ready     = 1'b0;
        m_valid     = 1'b0;

        // consume the element read last cycle
        if (pend_reg) begin
            if (is_sum_reg) begin
                acc_next = acc_reg + rd32[SW-1:0];
            end else begin
                we = 1'b1;
            end
        end

        case (state_reg)
            rxrs_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == 32'(MAX_ELEMENTS - 1)) begin
                    state_next = rxrs_pkg::ST_IDLE;
                end
            end
            rxrs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cur_next    = l_eff;
                    end_next    = r_eff;
                    mask_next   = s_value;
                    is_sum_next = (s_req_type == rxrs_pkg::REQ_SUM);
                    acc_next    = '0;
                    case (s_req_type)
                        rxrs_pkg::REQ_LOAD: begin
                            if (s_left != '0 && s_left <= cnt) begin
                                we    = 1'b1;
                                waddr = pos_addr(s_left);
                                wdata = s_value;
                            end
                        end
                        rxrs_pkg::REQ_XOR: begin
                            if (l_eff <= r_eff) begin
                                state_next = rxrs_pkg::ST_RUN;
                            end
                        end
                        rxrs_pkg::REQ_SUM: begin
                            state_next = (l_eff <= r_eff) ? rxrs_pkg::ST_RUN
                                                          : rxrs_pkg::ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rxrs_pkg::ST_RUN: begin
                pend_next  = 1'b1;
                paddr_next = pos_addr(cur_reg);
                cur_next   = cur_reg + PW'(1);
                if (cur_reg == end_reg) begin
                    state_next = rxrs_pkg::ST_DRAIN;
                end
            end
            rxrs_pkg::ST_DRAIN: begin
                state_next = is_sum_reg ? rxrs_pkg::ST_OUT : rxrs_pkg::ST_IDLE;
            end
            rxrs_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = rxrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rxrs_pkg::ST_IDLE;
            end
        endcase
        if (!accept && state_reg == rxrs_pkg::ST_IDLE) begin
            acc_next = acc_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rxrs_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= rxrs_pkg::COUNT_RESET;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        end_reg    <= end_next;
        is_sum_reg <= is_sum_next;
        mask_reg   <= mask_next;
        paddr_reg  <= paddr_next;
        acc_reg    <= acc_next;
    end

    rxrs_elem_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule
